@@ src/typed_literal_range_checker_macros.svh @@
// Assertion helpers for the checker file
`ifndef TYPED_LITERAL_RANGE_CHECKER_MACROS_SVH
`define TYPED_LITERAL_RANGE_CHECKER_MACROS_SVH

// Overlapping implication, sampled on the rising clock, off during reset
`define TLRC_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("tlrc: assertion failed");

// Non-overlapping implication, consequent starts in the following cycle
`define TLRC_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("tlrc: assertion failed");

`endif

@@ src/tlrc_pkg.sv @@
package tlrc_pkg;

  // Literal kinds
  localparam logic [2:0] KIND_INT      = 3'd0;
  localparam logic [2:0] KIND_LONG     = 3'd1;
  localparam logic [2:0] KIND_DATE     = 3'd2;
  localparam logic [2:0] KIND_MONTH    = 3'd3;
  localparam logic [2:0] KIND_MINUTE   = 3'd4;
  localparam logic [2:0] KIND_SECOND   = 3'd5;
  localparam logic [2:0] KIND_TIME     = 3'd6;
  localparam logic [2:0] KIND_DATETIME = 3'd7;

  // Target types; codes above TGT_OTHER are unused
  localparam logic [3:0] TGT_BOOL     = 4'd0;
  localparam logic [3:0] TGT_I8       = 4'd1;
  localparam logic [3:0] TGT_I16      = 4'd2;
  localparam logic [3:0] TGT_I32      = 4'd3;
  localparam logic [3:0] TGT_I64      = 4'd4;
  localparam logic [3:0] TGT_DATE     = 4'd5;
  localparam logic [3:0] TGT_MONTH    = 4'd6;
  localparam logic [3:0] TGT_MINUTE   = 4'd7;
  localparam logic [3:0] TGT_SECOND   = 4'd8;
  localparam logic [3:0] TGT_TIME     = 4'd9;
  localparam logic [3:0] TGT_DATETIME = 4'd10;
  localparam logic [3:0] TGT_OTHER    = 4'd11;

  // Time-of-day limits
  localparam int MIN_PER_DAY = 1440;
  localparam int SEC_PER_DAY = 86400;
  localparam int MS_PER_DAY  = 86400000;

  // Calendar decoding
  localparam int DATE_W   = 27;     // yyyymmdd up to 99991231 fits
  localparam int YEAR_W   = 14;
  localparam int YEAR_MIN = 1000;
  localparam int YEAR_MAX = 9999;
  localparam int CENT     = 100;
  localparam int YEAR_MUL = 10000;

  // Datetime: every valid word is below 2^DT_BITS (99991232 days of ms)
  localparam int DT_BITS   = 53;
  localparam int DAY_SHIFT = 10;                // 86400000 = 2^10 * 84375
  localparam int DAY_ODD   = 84375;
  localparam int DT_HI_LSB = 26;                // y >> 16 with y = x >> 10
  localparam int REM_W     = 19;
  localparam logic [31:0] DAY_RECIP = 32'((64'd1 << 48) / 64'(DAY_ODD));

  // Reciprocals for truncating division by 10000 and 100
  localparam int SHIFT_1E4 = 41;
  localparam logic [27:0] RECIP_1E4 =
    28'(((64'd1 << SHIFT_1E4) + 64'(YEAR_MUL) - 64'd1) / 64'(YEAR_MUL));
  localparam int SHIFT_100 = 21;
  localparam logic [14:0] RECIP_100 =
    15'(((64'd1 << SHIFT_100) + 64'(CENT) - 64'd1) / 64'(CENT));

  // Classifier result for one word
  typedef struct packed {
    logic              simple_ok;  // verdict for kinds that need no decode
    logic              dpath;      // calendar decode decides the verdict
    logic              is_dt;      // decode input comes from the ms divider
    logic [DATE_W-1:0] d_pre;      // yyyymmdd for date and month kinds
  } cls_t;

  // Sideband carried alongside the date decoder
  typedef struct packed {
    logic simple_ok;
    logic dpath;
  } side_t;

endpackage

@@ src/typed_literal_range_checker.sv @@
// Throughput: one word per cycle while busy is low; the result strobe cannot
// be held off. Depth is set by the reciprocal-multiply stages of the ms-per-day
// divider and the yyyymmdd decoder, each stage one multiplication deep.
// Reset (synchronous, active low) clears the valid pipeline; busy is high
// during reset and in the cycle after it.
module typed_literal_range_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_cmd,
  input  logic signed [63:0] in_value,
  input  logic [3:0]         in_target_type,
  output logic               out_valid,
  output logic               out_valid_res
);

  localparam int SIDE_N = 4;
  localparam int VLD_N  = 7;

  logic                         busy_r;
  logic                         accept;
  logic [VLD_N-1:0]             vld_r;
  logic                         out_valid_r;
  logic                         res_nxt;
  logic                         res_r;
  logic [2:0]                   cmd_r;
  logic [63:0]                  value_r;
  logic [3:0]                   tgt_r;
  tlrc_pkg::cls_t               cls;
  tlrc_pkg::cls_t               cls1_r;
  tlrc_pkg::cls_t               cls2_r;
  tlrc_pkg::side_t              side_r [SIDE_N];
  logic [tlrc_pkg::DATE_W-1:0]  q;
  logic [tlrc_pkg::DATE_W-1:0]  d_sel;
  logic                         date_ok;

  assign accept = start & ~busy_r;

  // Control: busy after reset, valid bits along the pipe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= 1'b0;
      vld_r       <= {vld_r[VLD_N-2:0], accept};
      out_valid_r <= vld_r[VLD_N-1];
    end
  end

  // Input word register
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= in_cmd;
      value_r <= in_value;
      tgt_r   <= in_target_type;
    end
  end

  tlrc_classify u_classify (
    .cmd         (cmd_r),
    .value       (value_r),
    .target_type (tgt_r),
    .cls         (cls)
  );

  tlrc_ms_div u_ms_div (
    .clk (clk),
    .x   (value_r[tlrc_pkg::DT_BITS-1:0]),
    .q   (q)
  );

  // Classifier result follows the divider
  always_ff @(posedge clk) begin
    cls1_r <= cls;
    cls2_r <= cls1_r;
  end

  assign d_sel = cls2_r.is_dt ? q : cls2_r.d_pre;

  tlrc_date_dec u_date_dec (
    .clk (clk),
    .d   (d_sel),
    .ok  (date_ok)
  );

  // Sideband follows the date decoder
  always_ff @(posedge clk) begin
    side_r[0] <= '{simple_ok: cls2_r.simple_ok, dpath: cls2_r.dpath};
    for (int i = 1; i < SIDE_N; i++) begin
      side_r[i] <= side_r[i-1];
    end
  end

  // Result register
  assign res_nxt = side_r[SIDE_N-1].simple_ok | (side_r[SIDE_N-1].dpath & date_ok);

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign busy          = busy_r;
  assign out_valid     = out_valid_r;
  assign out_valid_res = res_r;

endmodule

@@ src/tlrc_classify.sv @@
module tlrc_classify (
  input  logic [2:0]     cmd,
  input  logic [63:0]    value,
  input  logic [3:0]     target_type,
  output tlrc_pkg::cls_t cls
);

  logic fits8;
  logic fits16;
  logic fits32;
  logic int_fit;

  // Sign-extension checks for the narrow integer ranges
  assign fits8  = (&value[63:7])  | ~(|value[63:7]);
  assign fits16 = (&value[63:15]) | ~(|value[63:15]);
  assign fits32 = (&value[63:31]) | ~(|value[63:31]);

  // Integer target range, i64 handled per kind
  always_comb begin
    int_fit = 1'b0;
    unique case (target_type)
      tlrc_pkg::TGT_BOOL: int_fit = ~(|value[63:1]);
      tlrc_pkg::TGT_I8:   int_fit = fits8;
      tlrc_pkg::TGT_I16:  int_fit = fits16;
      tlrc_pkg::TGT_I32:  int_fit = fits32;
      default:            int_fit = 1'b0;
    endcase
  end

  // Per-kind verdict or decode request; negatives fail unsigned compares
  always_comb begin
    cls.simple_ok = 1'b0;
    cls.dpath     = 1'b0;
    cls.is_dt     = 1'b0;
    cls.d_pre     = value[tlrc_pkg::DATE_W-1:0];
    unique case (cmd)
      tlrc_pkg::KIND_INT:
        cls.simple_ok = fits32 & int_fit;
      tlrc_pkg::KIND_LONG:
        cls.simple_ok = int_fit | (target_type == tlrc_pkg::TGT_I64);
      tlrc_pkg::KIND_DATE:
        cls.dpath = (target_type == tlrc_pkg::TGT_DATE) &&
                    (value[63:tlrc_pkg::DATE_W] == '0);
      tlrc_pkg::KIND_MONTH: begin
        // yyyymm becomes yyyymm01, so the date decoder checks it
        cls.dpath = (target_type == tlrc_pkg::TGT_MONTH) && (value[63:20] == '0);
        cls.d_pre = tlrc_pkg::DATE_W'(value[19:0]) * tlrc_pkg::DATE_W'(tlrc_pkg::CENT)
                    + tlrc_pkg::DATE_W'(1);
      end
      tlrc_pkg::KIND_MINUTE:
        cls.simple_ok = (target_type == tlrc_pkg::TGT_MINUTE) &&
                        (value < 64'(tlrc_pkg::MIN_PER_DAY));
      tlrc_pkg::KIND_SECOND:
        cls.simple_ok = (target_type == tlrc_pkg::TGT_SECOND) &&
                        (value < 64'(tlrc_pkg::SEC_PER_DAY));
      tlrc_pkg::KIND_TIME:
        cls.simple_ok = (target_type == tlrc_pkg::TGT_TIME) &&
                        (value < 64'(tlrc_pkg::MS_PER_DAY));
      tlrc_pkg::KIND_DATETIME: begin
        // time part of a day remainder is always a valid time of day
        cls.dpath = (target_type == tlrc_pkg::TGT_DATETIME) &&
                    (value[63:tlrc_pkg::DT_BITS] == '0);
        cls.is_dt = 1'b1;
      end
    endcase
  end

endmodule

@@ src/tlrc_ms_div.sv @@
// Day number of a millisecond count: q = x / 86400000, two register stages.
// x >> 10 is divided by 84375 with a reciprocal estimate off by at most one.
module tlrc_ms_div (
  input  logic                          clk,
  input  logic [tlrc_pkg::DT_BITS-1:0]  x,
  output logic [tlrc_pkg::DATE_W-1:0]   q
);

  localparam int PROD1_W = tlrc_pkg::DATE_W + 32;
  localparam int PROD2_W = tlrc_pkg::DATE_W + 17;

  logic [PROD1_W-1:0]             prod1;
  logic [tlrc_pkg::DATE_W-1:0]    q1_nxt;
  logic [tlrc_pkg::DATE_W-1:0]    q1_r;
  logic [tlrc_pkg::REM_W-1:0]     ylo_r;
  logic [PROD2_W-1:0]             prod2;
  logic [tlrc_pkg::REM_W-1:0]     rem_nxt;
  logic [tlrc_pkg::REM_W-1:0]     rem_r;
  logic [tlrc_pkg::DATE_W-1:0]    q2_r;

  // Estimate from the top bits, never above the true quotient
  always_comb begin
    prod1  = PROD1_W'(x[tlrc_pkg::DT_BITS-1:tlrc_pkg::DT_HI_LSB]) *
             PROD1_W'(tlrc_pkg::DAY_RECIP);
    q1_nxt = prod1[PROD1_W-1:32];
  end

  always_ff @(posedge clk) begin
    q1_r  <= q1_nxt;
    ylo_r <= x[tlrc_pkg::DAY_SHIFT +: tlrc_pkg::REM_W];
  end

  // Remainder of the estimate, small enough for the low bits alone
  always_comb begin
    prod2   = PROD2_W'(q1_r) * PROD2_W'(tlrc_pkg::DAY_ODD);
    rem_nxt = ylo_r - prod2[tlrc_pkg::REM_W-1:0];
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q2_r  <= q1_r;
  end

  // One correction step
  assign q = q2_r + tlrc_pkg::DATE_W'(rem_r >= tlrc_pkg::REM_W'(tlrc_pkg::DAY_ODD));

endmodule

@@ src/tlrc_date_dec.sv @@
// yyyymmdd check over four register stages; ok is valid after the fourth.
module tlrc_date_dec (
  input  logic                         clk,
  input  logic [tlrc_pkg::DATE_W-1:0]  d,
  output logic                         ok
);

  localparam int YW  = tlrc_pkg::YEAR_W;
  localparam int P1W = tlrc_pkg::DATE_W + 28;
  localparam int P2W = YW + 15;

  logic [tlrc_pkg::DATE_W-1:0] d_r;
  logic [tlrc_pkg::DATE_W-1:0] d2_r;
  logic [P1W-1:0]              p1;
  logic [YW-1:0]               yy_nxt;
  logic [YW-1:0]               yy_r;
  logic [YW-1:0]               rem_nxt;
  logic [YW-1:0]               rem_r;
  logic [YW-1:0]               yy3_r;
  logic [P2W-1:0]              pm;
  logic [P2W-1:0]              pc;
  logic [7:0]                  mm_r;
  logic [7:0]                  c_r;
  logic [YW-1:0]               rem4_r;
  logic [YW-1:0]               yy4_r;
  logic [6:0]                  dd;
  logic [6:0]                  yr_lo;
  logic                        leap;
  logic                        year_ok;
  logic                        mon_ok;
  logic [4:0]                  top;

  // Stage 1: register input word
  always_ff @(posedge clk) begin
    d_r <= d;
  end

  // Stage 2: year = d / 10000
  always_comb begin
    p1     = P1W'(d_r) * P1W'(tlrc_pkg::RECIP_1E4);
    yy_nxt = p1[tlrc_pkg::SHIFT_1E4 +: YW];
  end

  always_ff @(posedge clk) begin
    yy_r <= yy_nxt;
    d2_r <= d_r;
  end

  // Stage 3: mmdd = d - year * 10000
  always_comb begin
    rem_nxt = YW'(d2_r - tlrc_pkg::DATE_W'(tlrc_pkg::DATE_W'(yy_r) *
                                             tlrc_pkg::DATE_W'(tlrc_pkg::YEAR_MUL)));
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    yy3_r <= yy_r;
  end

  // Stage 4: month = mmdd / 100, century = year / 100
  always_comb begin
    pm = P2W'(rem_r) * P2W'(tlrc_pkg::RECIP_100);
    pc = P2W'(yy3_r) * P2W'(tlrc_pkg::RECIP_100);
  end

  always_ff @(posedge clk) begin
    mm_r   <= pm[tlrc_pkg::SHIFT_100 +: 8];
    c_r    <= pc[tlrc_pkg::SHIFT_100 +: 8];
    rem4_r <= rem_r;
    yy4_r  <= yy3_r;
  end

  // Day and low year digits, then the calendar rules
  always_comb begin
    dd    = 7'(rem4_r - YW'(YW'(mm_r) * YW'(tlrc_pkg::CENT)));
    yr_lo = 7'(yy4_r - YW'(YW'(c_r) * YW'(tlrc_pkg::CENT)));
    // Gregorian: by 4, and not by 100 unless by 400
    leap    = (yy4_r[1:0] == 2'd0) && ((yr_lo != 7'd0) || (c_r[1:0] == 2'd0));
    year_ok = (yy4_r >= YW'(tlrc_pkg::YEAR_MIN)) && (yy4_r <= YW'(tlrc_pkg::YEAR_MAX));
    mon_ok  = (mm_r >= 8'd1) && (mm_r <= 8'd12);
    case (mm_r)
      8'd2:                       top = leap ? 5'd29 : 5'd28;
      8'd4, 8'd6, 8'd9, 8'd11:    top = 5'd30;
      default:                    top = 5'd31;
    endcase
    ok = year_ok && mon_ok && (dd >= 7'd1) && (dd <= 7'(top));
  end

endmodule

@@ src/tlrc_checker.sv @@
`include "typed_literal_range_checker_macros.svh"

module tlrc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic [2:0] in_cmd,
  input logic [3:0] in_target_type,
  input logic       out_valid,
  input logic       out_valid_res
);

  localparam int LAT = 8;

  logic acc;
  logic acc_other;
  logic acc_long64;

  assign acc = start & ~busy;

  // Accepted words of interest for the verdict checks
  assign acc_other  = acc && (in_target_type == tlrc_pkg::TGT_OTHER);
  assign acc_long64 = acc && (in_cmd == tlrc_pkg::KIND_LONG) &&
                      (in_target_type == tlrc_pkg::TGT_I64);

  // Every accepted word gives one strobe after the fixed latency
  `TLRC_ASSERT_NXT(a_latency, clk, rst_n, acc, ##(LAT-1) out_valid)
  // No strobe without a word accepted at that distance
  `TLRC_ASSERT_IMP(a_no_spurious, clk, rst_n, out_valid, $past(acc, LAT))
  // The other target type takes no literal
  `TLRC_ASSERT_IMP(a_other_rejected, clk, rst_n, acc_other, ##LAT !out_valid_res)
  // Any long fits i64
  `TLRC_ASSERT_IMP(a_long_i64, clk, rst_n, acc_long64, ##LAT out_valid_res)

endmodule

bind typed_literal_range_checker tlrc_checker u_tlrc_checker (.*);

@@ tb/typed_literal_range_checker_tb.sv @@
module typed_literal_range_checker_tb;

  localparam longint I32_LO = -64'sd2147483648;
  localparam longint I32_HI = 64'sd2147483647;
  localparam longint MS_DAY = 64'sd86400000;
  localparam longint YR_FIRST = 1000;
  localparam longint YR_LAST = 9999;
  localparam longint WRAP_32 = 64'sd4294967296;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 16;
  // unused target code at the top of the field
  localparam logic [3:0] TGT_UNUSED = 4'd15;

  typedef struct {
    logic [2:0]         kind;
    logic signed [63:0] value;
    logic [3:0]         tgt;
    logic               fits;
  } word_check_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [2:0]         in_cmd = '0;
  logic signed [63:0] in_value = '0;
  logic [3:0]         in_target_type = '0;
  logic               out_valid;
  logic               out_valid_res;

  word_check_t fits_q[$];
  int          mismatch_cnt = 0;
  int          cycle_cnt = 0;

  typed_literal_range_checker u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_cmd        (in_cmd),
    .in_value      (in_value),
    .in_target_type(in_target_type),
    .out_valid     (out_valid),
    .out_valid_res (out_valid_res)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // yyyymmdd with Gregorian month lengths, years 1000..9999
  function automatic logic date_fits(longint x);
    longint yr, mo, dd, last;
    if (x < 0) return 1'b0;
    yr = x / 10000;
    mo = (x / 100) % 100;
    dd = x % 100;
    if (yr < YR_FIRST || yr > YR_LAST || mo < 1 || mo > 12) return 1'b0;
    if (mo == 2) begin
      last = ((yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0))) ? 29 : 28;
    end else if (mo == 4 || mo == 6 || mo == 9 || mo == 11) begin
      last = 30;
    end else begin
      last = 31;
    end
    return (dd >= 1) && (dd <= last);
  endfunction

  // Expected flag for one word
  function automatic logic literal_fits(logic [2:0] kind, logic signed [63:0] v,
                                        logic [3:0] tgt);
    longint x;
    logic   in_i32;
    logic   int_ok;
    x = v;
    in_i32 = (x >= I32_LO) && (x <= I32_HI);
    case (tgt)
      tlrc_pkg::TGT_BOOL: int_ok = (x == 0) || (x == 1);
      tlrc_pkg::TGT_I8:   int_ok = (x >= -128) && (x <= 127);
      tlrc_pkg::TGT_I16:  int_ok = (x >= -32768) && (x <= 32767);
      tlrc_pkg::TGT_I32:  int_ok = in_i32;
      tlrc_pkg::TGT_I64:  int_ok = (kind == tlrc_pkg::KIND_LONG);
      default:            int_ok = 1'b0;
    endcase
    case (kind)
      tlrc_pkg::KIND_INT:    return in_i32 && int_ok;
      tlrc_pkg::KIND_LONG:   return int_ok;
      tlrc_pkg::KIND_DATE:   return (tgt == tlrc_pkg::TGT_DATE) && in_i32 && date_fits(x);
      tlrc_pkg::KIND_MONTH:  return (tgt == tlrc_pkg::TGT_MONTH) && in_i32 && (x >= 0) &&
                                    (x / 100 >= YR_FIRST) && (x / 100 <= YR_LAST) &&
                                    (x % 100 >= 1) && (x % 100 <= 12);
      tlrc_pkg::KIND_MINUTE: return (tgt == tlrc_pkg::TGT_MINUTE) && in_i32 &&
                                    (x >= 0) && (x < 1440);
      tlrc_pkg::KIND_SECOND: return (tgt == tlrc_pkg::TGT_SECOND) && in_i32 &&
                                    (x >= 0) && (x < 86400);
      tlrc_pkg::KIND_TIME:   return (tgt == tlrc_pkg::TGT_TIME) && in_i32 &&
                                    (x >= 0) && (x < MS_DAY);
      default:               return (tgt == tlrc_pkg::TGT_DATETIME) && (x >= 0) &&
                                    date_fits(x / MS_DAY);
    endcase
  endfunction

  // Record accepted words, check each result against the oldest expectation
  always @(posedge clk) begin
    word_check_t w;
    if (rst_n && start && !busy) begin
      w.kind = in_cmd;
      w.value = in_value;
      w.tgt = in_target_type;
      w.fits = literal_fits(in_cmd, in_value, in_target_type);
      fits_q.push_back(w);
    end
    if (rst_n && out_valid) begin
      if (fits_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result: valid_res %0b with nothing pending", out_valid_res);
      end else begin
        w = fits_q.pop_front();
        if (out_valid_res !== w.fits) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: cmd %0d value %0d target %0d expected %0b got %0b",
                     w.kind, w.value, w.tgt, w.fits, out_valid_res);
        end
      end
    end
  end

  // Run guard
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Send one word, optionally after an idle burst; returns on acceptance
  task automatic send_word(input logic [2:0] kind, input logic signed [63:0] v,
                           input logic [3:0] tgt, input int idle);
    if (idle > 0) begin
      start <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    start <= 1'b1;
    in_cmd <= kind;
    in_value <= v;
    in_target_type <= tgt;
    do @(posedge clk); while (busy);
  endtask

  // Mostly well-formed words near the range edges, some noise
  task automatic make_random_word(output logic [2:0] kind, output logic signed [63:0] v,
                                  output logic [3:0] tgt);
    int     sel;
    longint yr, mo, dd, dval;
    sel = $urandom_range(0, 99);
    kind = 3'($urandom_range(0, 7));
    // calendar fields, biased toward year and month-end edges
    case ($urandom_range(0, 3))
      0:       yr = $urandom_range(0, 1) ? $urandom_range(995, 1004)
                                         : $urandom_range(9995, 10004);
      1:       yr = $urandom_range(10, 99) * 100;
      default: yr = $urandom_range(1000, 9999);
    endcase
    mo = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 13) : $urandom_range(1, 12);
    dd = $urandom_range(0, 1) ? $urandom_range(26, 32) : $urandom_range(0, 32);
    dval = yr * 10000 + mo * 100 + dd;
    case (kind)
      tlrc_pkg::KIND_INT, tlrc_pkg::KIND_LONG: begin
        tgt = 4'($urandom_range(0, 4));
        case ($urandom_range(0, 7))
          0: v = 64'sd0;
          1: v = 64'sd127;
          2: v = -64'sd128;
          3: v = 64'sd32767;
          4: v = -64'sd32768;
          5: v = I32_HI;
          6: v = I32_LO;
          default: v = longint'($signed($urandom));
        endcase
        v = v + $urandom_range(0, 4) - 2;
      end
      tlrc_pkg::KIND_DATE: begin
        tgt = tlrc_pkg::TGT_DATE;
        v = dval;
      end
      tlrc_pkg::KIND_MONTH: begin
        tgt = tlrc_pkg::TGT_MONTH;
        v = yr * 100 + mo;
      end
      tlrc_pkg::KIND_MINUTE: begin
        tgt = tlrc_pkg::TGT_MINUTE;
        v = $urandom_range(0, 1) ? $urandom_range(0, 1439) : $urandom_range(1435, 1445);
      end
      tlrc_pkg::KIND_SECOND: begin
        tgt = tlrc_pkg::TGT_SECOND;
        v = $urandom_range(0, 1) ? $urandom_range(0, 86399) : $urandom_range(86395, 86405);
      end
      tlrc_pkg::KIND_TIME: begin
        tgt = tlrc_pkg::TGT_TIME;
        v = $urandom_range(0, 1) ? $urandom_range(0, 86399999)
                                 : $urandom_range(86399995, 86400005);
      end
      default: begin
        tgt = tlrc_pkg::TGT_DATETIME;
        v = dval * MS_DAY + $urandom_range(0, 86399999);
      end
    endcase
    // broken words: wrong sign, outside i32, wrong target, raw noise
    if (sel < 5) v = -v;
    else if (sel < 10) v = v + WRAP_32;
    else if (sel < 18) tgt = 4'($urandom_range(0, 15));
    else if (sel < 30) begin
      v = {$urandom, $urandom};
      tgt = 4'($urandom_range(0, 15));
    end
  endtask

  task automatic test_int_kinds();
    send_word(tlrc_pkg::KIND_INT, 64'sd1, tlrc_pkg::TGT_BOOL, 0);
    send_word(tlrc_pkg::KIND_INT, 64'sd2, tlrc_pkg::TGT_BOOL, 0);
    send_word(tlrc_pkg::KIND_INT, -64'sd128, tlrc_pkg::TGT_I8, 0);
    send_word(tlrc_pkg::KIND_INT, 64'sd128, tlrc_pkg::TGT_I8, 0);
    send_word(tlrc_pkg::KIND_INT, 64'sd32767, tlrc_pkg::TGT_I16, 0);
    send_word(tlrc_pkg::KIND_INT, I32_LO, tlrc_pkg::TGT_I32, 0);
    // int kind outside i32 and int aimed at i64 are both rejected
    send_word(tlrc_pkg::KIND_INT, I32_HI + 1, tlrc_pkg::TGT_I32, 0);
    send_word(tlrc_pkg::KIND_INT, 64'sd5, tlrc_pkg::TGT_I64, 0);
    send_word(tlrc_pkg::KIND_LONG, 64'h8000_0000_0000_0000, tlrc_pkg::TGT_I64, 0);
    send_word(tlrc_pkg::KIND_LONG, 64'h7fff_ffff_ffff_ffff, tlrc_pkg::TGT_I32, 0);
  endtask

  task automatic test_calendar_kinds();
    // leap rules on century years, year limits, sign and i32 limits, then month, time and datetime edges
    send_word(tlrc_pkg::KIND_DATE, 64'sd20000229, tlrc_pkg::TGT_DATE, 0);
    send_word(tlrc_pkg::KIND_DATE, 64'sd19000229, tlrc_pkg::TGT_DATE, 0);
    send_word(tlrc_pkg::KIND_DATE, 64'sd10000101, tlrc_pkg::TGT_DATE, 0);
    send_word(tlrc_pkg::KIND_DATE, 64'sd99991231, tlrc_pkg::TGT_DATE, 0);
    send_word(tlrc_pkg::KIND_DATE, 64'sd9991231, tlrc_pkg::TGT_DATE, 0);
    send_word(tlrc_pkg::KIND_DATE, -64'sd20000101, tlrc_pkg::TGT_DATE, 0);
    send_word(tlrc_pkg::KIND_DATE, WRAP_32 + 64'sd20000101, tlrc_pkg::TGT_DATE, 0);
    send_word(tlrc_pkg::KIND_MONTH, 64'sd999912, tlrc_pkg::TGT_MONTH, 0);
    send_word(tlrc_pkg::KIND_MONTH, 64'sd100013, tlrc_pkg::TGT_MONTH, 0);
    send_word(tlrc_pkg::KIND_MINUTE, 64'sd1439, tlrc_pkg::TGT_MINUTE, 0);
    send_word(tlrc_pkg::KIND_MINUTE, 64'sd1440, tlrc_pkg::TGT_MINUTE, 0);
    send_word(tlrc_pkg::KIND_SECOND, 64'sd86399, tlrc_pkg::TGT_SECOND, 0);
    send_word(tlrc_pkg::KIND_TIME, 64'sd86399999, tlrc_pkg::TGT_TIME, 0);
    send_word(tlrc_pkg::KIND_DATETIME, 64'sd99991231 * MS_DAY + 64'sd86399999,
              tlrc_pkg::TGT_DATETIME, 0);
    send_word(tlrc_pkg::KIND_DATETIME, -64'sd1, tlrc_pkg::TGT_DATETIME, 0);
  endtask

  task automatic test_bad_targets();
    send_word(tlrc_pkg::KIND_DATE, 64'sd20000101, tlrc_pkg::TGT_MONTH, 0);
    send_word(tlrc_pkg::KIND_TIME, 64'sd0, tlrc_pkg::TGT_OTHER, 0);
    send_word(tlrc_pkg::KIND_LONG, 64'sd0, TGT_UNUSED, 0);
  endtask

  task automatic test_random_mix();
    logic [2:0]         kind;
    logic signed [63:0] v;
    logic [3:0]         tgt;
    repeat (600) begin
      make_random_word(kind, v, tgt);
      send_word(kind, v, tgt,
                ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0);
    end
  endtask

  // closing stretch at full rate
  task automatic test_steady_stream();
    logic [2:0]         kind;
    logic signed [63:0] v;
    logic [3:0]         tgt;
    repeat (150) begin
      make_random_word(kind, v, tgt);
      send_word(kind, v, tgt, 0);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_int_kinds();
    test_calendar_kinds();
    test_bad_targets();
    test_random_mix();
    test_steady_stream();
    start <= 1'b0;
    @(posedge clk);
    while (fits_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
